FILE: rtl/core/ssis_pkg.sv
// Shared types, codes and the control store of the sorted set core.
`default_nettype none

package ssis_pkg;

  localparam int unsigned StatusW = 3;
  localparam int unsigned IndexW  = 7;
  localparam int unsigned CountW  = 8;
  localparam int unsigned CapW    = 8;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned StepW   = 4;

  localparam logic [CapW-1:0] CapReset = 8'd128;

  localparam logic [StatusW-1:0] StInserted  = 3'd0;
  localparam logic [StatusW-1:0] StDuplicate = 3'd1;
  localparam logic [StatusW-1:0] StFull      = 3'd2;
  localparam logic [StatusW-1:0] StFound     = 3'd3;
  localparam logic [StatusW-1:0] StNotFound  = 3'd4;

  localparam logic FuncInsert = 1'b0;
  localparam logic FuncSearch = 1'b1;

  localparam logic [StepW-1:0] S_IDLE = 4'd0;
  localparam logic [StepW-1:0] S_CHK  = 4'd1;
  localparam logic [StepW-1:0] S_FULL = 4'd2;
  localparam logic [StepW-1:0] S_SRCH = 4'd3;
  localparam logic [StepW-1:0] S_CMP  = 4'd4;
  localparam logic [StepW-1:0] S_HIT  = 4'd5;
  localparam logic [StepW-1:0] S_MISS = 4'd6;
  localparam logic [StepW-1:0] S_SHRD = 4'd7;
  localparam logic [StepW-1:0] S_SHMV = 4'd8;
  localparam logic [StepW-1:0] S_PUT  = 4'd9;
  localparam logic [StepW-1:0] S_DONE = 4'd10;

  typedef enum logic [1:0] {RD_NONE, RD_MID, RD_PM1, RD_PM2} rd_e;
  typedef enum logic [1:0] {WR_NONE, WR_SHIFT, WR_VALUE} wr_e;
  typedef enum logic [1:0] {BND_NONE, BND_INIT, BND_NARROW, BND_PDEC} bnd_e;
  typedef enum logic [2:0] {RES_NONE, RES_FULL, RES_HIT, RES_MISS, RES_INS} res_e;
  typedef enum logic [3:0] {
    C_ALWAYS, C_IN_VALID, C_FULL, C_LT, C_EQ, C_SEARCH, C_PGT, C_PGT1, C_OUT_FREE
  } cond_e;

  typedef struct packed {
    logic             take;
    logic             emit;
    rd_e              rd;
    wr_e              wr;
    bnd_e             bnd;
    res_e             res;
    cond_e            cond;
    logic [StepW-1:0] tgt_t;
    logic [StepW-1:0] tgt_f;
  } ctl_t;

  typedef struct packed {
    logic in_valid;
    logic full;
    logic lt;
    logic eq;
    logic search;
    logic pgt;
    logic pgt1;
    logic out_free;
  } flags_t;

  // Control store: one control word per step.
  function automatic ctl_t ucode(input logic [StepW-1:0] step);
    ctl_t c;
    c = '0;
    c.cond  = C_ALWAYS;
    c.tgt_t = S_IDLE;
    c.tgt_f = S_IDLE;
    case (step)
      S_IDLE: begin
        c.take = 1'b1; c.bnd = BND_INIT;
        c.cond = C_IN_VALID; c.tgt_t = S_CHK; c.tgt_f = S_IDLE;
      end
      S_CHK: begin
        c.cond = C_FULL; c.tgt_t = S_FULL; c.tgt_f = S_SRCH;
      end
      S_FULL: begin
        c.res = RES_FULL; c.tgt_t = S_DONE;
      end
      S_SRCH: begin
        c.rd = RD_MID;
        c.cond = C_LT; c.tgt_t = S_CMP; c.tgt_f = S_MISS;
      end
      S_CMP: begin
        c.bnd = BND_NARROW;
        c.cond = C_EQ; c.tgt_t = S_HIT; c.tgt_f = S_SRCH;
      end
      S_HIT: begin
        c.res = RES_HIT; c.tgt_t = S_DONE;
      end
      S_MISS: begin
        c.res = RES_MISS;
        c.cond = C_SEARCH; c.tgt_t = S_DONE; c.tgt_f = S_SHRD;
      end
      S_SHRD: begin
        c.rd = RD_PM1;
        c.cond = C_PGT; c.tgt_t = S_SHMV; c.tgt_f = S_PUT;
      end
      S_SHMV: begin
        c.wr = WR_SHIFT; c.rd = RD_PM2; c.bnd = BND_PDEC;
        c.cond = C_PGT1; c.tgt_t = S_SHMV; c.tgt_f = S_PUT;
      end
      S_PUT: begin
        c.wr = WR_VALUE; c.res = RES_INS; c.tgt_t = S_DONE;
      end
      S_DONE: begin
        c.emit = 1'b1;
        c.cond = C_OUT_FREE; c.tgt_t = S_IDLE; c.tgt_f = S_DONE;
      end
      default: begin
        c.tgt_t = S_IDLE;
      end
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/sorted_set_insert_search_core.sv
// Sorted set core: ascending array of distinct signed words with insert and binary search.
// An input word carries func_i (0 insert, 1 search) and value_i on a valid/ready channel.
// Every input word yields one result word (status_o, index_o, count_o) on a valid/ready
// output channel. The user must write the capacity register (cfg_we_i/cfg_data_i) only
// while idle; the core itself does not enforce this. The core works on one word at a time,
// stepped by a microcode sequencer. Each binary search probe is a memory read step (S_SRCH)
// followed by a compare step (S_CMP); a search makes at most ceil(log2(count+1)) probes.
// An insert that misses then moves each entry above the insertion point up one slot
// (S_SHRD, S_SHMV), reading each entry while the one above it is written, then stores the key (S_PUT).
// The result sits in an output register; the next input word is accepted while it waits.
// If the receiver stalls and a second result is ready, the core holds in its last step
// until the output register frees up.
// Reset empties the set and sets capacity to 128; the entry memory is not cleared,
// since only entries below the count are ever read.
`default_nettype none

module sorted_set_insert_search_core
  import ssis_pkg::*;
#(
  parameter int unsigned DEPTH = 128
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic        [CapW-1:0]    cfg_data_i,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic                      func_i,
  input  wire logic signed [ValueW-1:0]  value_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic             [StatusW-1:0] status_o,
  output logic             [IndexW-1:0]  index_o,
  output logic             [CountW-1:0]  count_o
);

  ctl_t   ctl;
  flags_t flags;

  assign in_ready_o = ctl.take;

  ssis_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .ctl_o   (ctl)
  );

  ssis_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .flags_o     (flags),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .func_i      (func_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .index_o     (index_o),
    .count_o     (count_o)
  );

endmodule

`default_nettype wire

FILE: rtl/core/ssis_seq.sv
// Microcode sequencer: step counter, control store lookup and conditional jumps.
`default_nettype none

module ssis_seq
  import ssis_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire flags_t flags_i,
  output ctl_t        ctl_o
);

  logic [StepW-1:0] step_q, step_d;
  logic             cond_hit;

  assign ctl_o = ucode(step_q);

  always_comb begin
    case (ctl_o.cond)
      C_ALWAYS:   cond_hit = 1'b1;
      C_IN_VALID: cond_hit = flags_i.in_valid;
      C_FULL:     cond_hit = flags_i.full;
      C_LT:       cond_hit = flags_i.lt;
      C_EQ:       cond_hit = flags_i.eq;
      C_SEARCH:   cond_hit = flags_i.search;
      C_PGT:      cond_hit = flags_i.pgt;
      C_PGT1:     cond_hit = flags_i.pgt1;
      C_OUT_FREE: cond_hit = flags_i.out_free;
      default:    cond_hit = 1'b1;
    endcase
    step_d = cond_hit ? ctl_o.tgt_t : ctl_o.tgt_f;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= S_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/ssis_dp.sv
// Datapath of the sorted set core: entry memory, search bounds, result and output registers.
`default_nettype none

module ssis_dp
  import ssis_pkg::*;
#(
  parameter int unsigned DEPTH = 128
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire ctl_t                       ctl_i,
  output flags_t                          flags_o,
  input  wire logic                       cfg_we_i,
  input  wire logic        [CapW-1:0]     cfg_data_i,
  input  wire logic                       in_valid_i,
  input  wire logic                       func_i,
  input  wire logic signed [ValueW-1:0]   value_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic             [StatusW-1:0]  status_o,
  output logic             [IndexW-1:0]   index_o,
  output logic             [CountW-1:0]   count_o
);

  localparam int unsigned AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned MaxCnt = (DEPTH < 255) ? DEPTH : 255;
  localparam int unsigned CntW   = $clog2(MaxCnt + 1);
  localparam int unsigned CmpW   = ($clog2(DEPTH + 1) > CapW) ? $clog2(DEPTH + 1) : CapW;

  logic signed [ValueW-1:0] mem [DEPTH];
  logic signed [ValueW-1:0] rdata_q;
  logic signed [ValueW-1:0] key_q;
  logic                     func_q;
  logic        [CapW-1:0]   cap_q;
  logic        [CntW-1:0]   count_q, lo_q, hi_q, p_q, mid_q;
  logic        [CntW-1:0]   mid, pm1, pm2;
  logic        [CntW:0]     sum;
  logic        [StatusW-1:0] status_q;
  logic        [CntW-1:0]   idx_q;
  logic                     out_valid_q;
  logic                     out_free, accept;
  logic                     re, we;
  logic        [AW-1:0]     raddr, waddr;
  logic signed [ValueW-1:0] wdata;

  assign sum      = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid      = sum[CntW:1];
  assign pm1      = p_q - CntW'(1);
  assign pm2      = p_q - CntW'(2);
  assign out_free = !out_valid_q || out_ready_i;
  assign accept   = ctl_i.take && in_valid_i;

  always_comb begin
    flags_o.in_valid = in_valid_i;
    flags_o.full     = (func_q == FuncInsert) &&
                       ((CmpW'(count_q) >= CmpW'(cap_q)) || (CmpW'(count_q) >= CmpW'(DEPTH)));
    flags_o.lt       = lo_q < hi_q;
    flags_o.eq       = rdata_q == key_q;
    flags_o.search   = func_q == FuncSearch;
    flags_o.pgt      = p_q > lo_q;
    flags_o.pgt1     = pm1 > lo_q;
    flags_o.out_free = out_free;
  end

  always_comb begin
    re    = 1'b1;
    raddr = AW'(mid);
    case (ctl_i.rd)
      RD_MID:  raddr = AW'(mid);
      RD_PM1:  raddr = AW'(pm1);
      RD_PM2:  raddr = AW'(pm2);
      default: re = 1'b0;
    endcase
    we    = 1'b1;
    waddr = AW'(p_q);
    wdata = rdata_q;
    case (ctl_i.wr)
      WR_SHIFT: begin
        waddr = AW'(p_q);
        wdata = rdata_q;
      end
      WR_VALUE: begin
        waddr = AW'(lo_q);
        wdata = key_q;
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q  <= value_i;
      func_q <= func_i;
    end
    if (ctl_i.rd == RD_MID) begin
      mid_q <= mid;
    end
    case (ctl_i.res)
      RES_FULL: begin
        status_q <= StFull;
        idx_q    <= '0;
      end
      RES_HIT: begin
        status_q <= (func_q == FuncSearch) ? StFound : StDuplicate;
        idx_q    <= (func_q == FuncSearch) ? mid_q : '0;
      end
      RES_MISS: begin
        status_q <= StNotFound;
        idx_q    <= '0;
      end
      RES_INS: begin
        status_q <= StInserted;
        idx_q    <= lo_q;
      end
      default: begin
      end
    endcase
    if (ctl_i.emit && out_free) begin
      status_o <= status_q;
      index_o  <= IndexW'(idx_q);
      count_o  <= CountW'(count_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CapReset;
      count_q     <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      p_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
      if (ctl_i.res == RES_INS) begin
        count_q <= count_q + CntW'(1);
      end
      case (ctl_i.bnd)
        BND_INIT: begin
          lo_q <= '0;
          hi_q <= count_q;
          p_q  <= count_q;
        end
        BND_NARROW: begin
          if (rdata_q != key_q) begin
            if (rdata_q < key_q) begin
              lo_q <= mid_q + CntW'(1);
            end else begin
              hi_q <= mid_q;
            end
          end
        end
        BND_PDEC: begin
          p_q <= pm1;
        end
        default: begin
        end
      endcase
      if (ctl_i.emit && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire
